// ===== rtl/core/cre_pkg.sv =====
// Shared types and constants of the 8-bit register and flag execute unit.
`default_nettype none

package cre_pkg;

    typedef enum logic [3:0] {
        MODE_ADC = 4'd0,
        MODE_CMP = 4'd1,
        MODE_CPX = 4'd2,
        MODE_CPY = 4'd3,
        MODE_INX = 4'd4,
        MODE_INY = 4'd5,
        MODE_DEX = 4'd6,
        MODE_LDA = 4'd7,
        MODE_LDX = 4'd8,
        MODE_LDY = 4'd9,
        MODE_TAX = 4'd10,
        MODE_TAY = 4'd11,
        MODE_STA = 4'd12,
        MODE_STX = 4'd13,
        MODE_STY = 4'd14
    } mode_t;

    localparam int unsigned FLAG_N_BIT = 7;
    localparam int unsigned FLAG_V_BIT = 6;
    localparam int unsigned FLAG_Z_BIT = 1;
    localparam int unsigned FLAG_C_BIT = 0;

    localparam logic [7:0] STATUS_RESET = 8'h34;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] operand;
    } in_item_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] xreg_out;
        logic [7:0] yreg_out;
        logic [7:0] flags_out;
        logic [7:0] store_data;
        logic       store_valid;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/cre_chan_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`default_nettype none

interface cre_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cre_in_stage.sv =====
// Input register that holds one accepted operation beat.
`default_nettype none

module cre_in_stage
    import cre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    input  wire logic     advance,
    output logic          held_valid,
    output in_item_t      held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cre_exec.sv =====
// Architectural registers A, X, Y and status with the add, compare and move logic.
`default_nettype none

module cre_exec
    import cre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     execute,
    input  wire in_item_t item,
    output out_item_t     result
);

    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] x_reg;
    logic [7:0] x_next;
    logic [7:0] y_reg;
    logic [7:0] y_next;
    logic [7:0] p_reg;
    logic [7:0] p_next;

    logic [8:0] sum;
    logic [7:0] cmp_src;
    logic [8:0] diff;
    logic [7:0] nz_val;
    logic       nz_upd;
    logic [7:0] sdata;
    logic       svalid;

    assign sum  = {1'b0, acc_reg} + {1'b0, item.operand} + {8'd0, p_reg[FLAG_C_BIT]};
    assign diff = {1'b0, cmp_src} - {1'b0, item.operand};

    always_comb
    begin
        case (item.mode)
            MODE_CPX: cmp_src = x_reg;
            MODE_CPY: cmp_src = y_reg;
            default:  cmp_src = acc_reg;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        p_next   = p_reg;
        nz_val   = 8'd0;
        nz_upd   = 1'b0;
        sdata    = 8'd0;
        svalid   = 1'b0;
        case (item.mode)
            MODE_ADC:
            begin
                acc_next              = sum[7:0];
                nz_val                = sum[7:0];
                nz_upd                = 1'b1;
                p_next[FLAG_C_BIT]    = sum[8];
                p_next[FLAG_V_BIT]    = ~(acc_reg[7] ^ item.operand[7]) & (acc_reg[7] ^ sum[7]);
            end
            MODE_CMP, MODE_CPX, MODE_CPY:
            begin
                p_next[FLAG_N_BIT] = diff[7];
                p_next[FLAG_Z_BIT] = (diff[7:0] == 8'd0);
                p_next[FLAG_C_BIT] = !diff[8];
            end
            MODE_INX:
            begin
                x_next = x_reg + 8'd1;
                nz_val = x_next;
                nz_upd = 1'b1;
            end
            MODE_INY:
            begin
                y_next = y_reg + 8'd1;
                nz_val = y_next;
                nz_upd = 1'b1;
            end
            MODE_DEX:
            begin
                x_next = x_reg - 8'd1;
                nz_val = x_next;
                nz_upd = 1'b1;
            end
            MODE_LDA:
            begin
                acc_next = item.operand;
                nz_val   = item.operand;
                nz_upd   = 1'b1;
            end
            MODE_LDX:
            begin
                x_next = item.operand;
                nz_val = item.operand;
                nz_upd = 1'b1;
            end
            MODE_LDY:
            begin
                y_next = item.operand;
                nz_val = item.operand;
                nz_upd = 1'b1;
            end
            MODE_TAX:
            begin
                x_next = acc_reg;
                nz_val = acc_reg;
                nz_upd = 1'b1;
            end
            MODE_TAY:
            begin
                y_next = acc_reg;
                nz_val = acc_reg;
                nz_upd = 1'b1;
            end
            MODE_STA:
            begin
                sdata  = acc_reg;
                svalid = 1'b1;
            end
            MODE_STX:
            begin
                sdata  = x_reg;
                svalid = 1'b1;
            end
            MODE_STY:
            begin
                sdata  = y_reg;
                svalid = 1'b1;
            end
            default:
            begin
                svalid = 1'b0;
            end
        endcase
        if (nz_upd)
        begin
            p_next[FLAG_N_BIT] = nz_val[7];
            p_next[FLAG_Z_BIT] = (nz_val == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
            p_reg   <= STATUS_RESET;
        end
        else if (execute)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            p_reg   <= p_next;
        end
    end

    assign result.acc_out     = acc_next;
    assign result.xreg_out    = x_next;
    assign result.yreg_out    = y_next;
    assign result.flags_out   = p_next;
    assign result.store_data  = sdata;
    assign result.store_valid = svalid;

endmodule

`default_nettype wire

// ===== rtl/core/cre_out_stage.sv =====
// Result register that holds one finished beat until the receiver takes it.
`default_nettype none

module cre_out_stage
    import cre_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load_valid,
    output logic           load_ready,
    input  wire out_item_t load_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cpu8_register_flag_execute.sv =====
// Top level of the 8-bit execute unit that keeps A, X, Y and the status byte.
//
// Operation beats arrive on op_in (mode and operand) and each produces exactly
// one result beat on res_out with A, X, Y, status, store data and store strobe
// as they stand after that operation.
// An accepted beat sits in the input register; in the next cycle in which the
// result register is free or being emptied, it executes against the
// architectural registers and its result is loaded into the result register.
// An accepted beat passes through the input register and then the result
// register; while the receiver keeps ready high, one beat is accepted and one
// result is delivered every cycle.
// When the receiver stalls, the result register holds its beat, the pending
// beat waits in the input register, and op_in.ready drops once both are full.
// Reset clears A, X and Y to zero, sets the status byte to 34h and empties both
// registers, so no result is presented until a new beat arrives.
`default_nettype none

module cpu8_register_flag_execute
    import cre_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cre_chan_if.sink  op_in,
    cre_chan_if.source res_out
);

    logic      held_valid;
    in_item_t  held_item;
    logic      exec_ready;
    logic      execute;
    out_item_t exec_result;

    cre_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (op_in.valid),
        .in_ready   (op_in.ready),
        .in_item    (op_in.payload),
        .advance    (exec_ready),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    assign execute = held_valid && exec_ready;

    cre_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .execute(execute),
        .item   (held_item),
        .result (exec_result)
    );

    cre_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_ready (exec_ready),
        .load_item  (exec_result),
        .out_valid  (res_out.valid),
        .out_ready  (res_out.ready),
        .out_item   (res_out.payload)
    );

endmodule

`default_nettype wire

// ===== dv/cre_exec_checker.sv =====
// Checker for the execute unit: predicts each result beat from the accepted operations and compares.
module cre_exec_checker
    import cre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  logic        op_ready,
    input  in_item_t    op_beat,
    input  logic        res_valid,
    input  logic        res_ready,
    input  out_item_t   res_beat,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked
);

    logic [7:0] acc_q;
    logic [7:0] x_q;
    logic [7:0] y_q;
    logic [7:0] status_q;
    out_item_t  expected_results[$];

    function automatic logic [7:0] with_nz(logic [7:0] status, logic [7:0] value);
        logic [7:0] s;
        s = status;
        s[FLAG_N_BIT] = value[7];
        s[FLAG_Z_BIT] = (value == 8'h00);
        return s;
    endfunction

    task automatic execute_op(input in_item_t op);
        out_item_t  r;
        logic [8:0] sum;
        logic [7:0] cmp_reg;
        logic [7:0] diff;
        r = '0;
        case (op.mode)
            MODE_ADC:
            begin
                sum = {1'b0, acc_q} + {1'b0, op.operand} + {8'd0, status_q[FLAG_C_BIT]};
                status_q = with_nz(status_q, sum[7:0]);
                status_q[FLAG_V_BIT] = (acc_q[7] == op.operand[7]) && (sum[7] != acc_q[7]);
                status_q[FLAG_C_BIT] = sum[8];
                acc_q = sum[7:0];
            end
            MODE_CMP, MODE_CPX, MODE_CPY:
            begin
                cmp_reg = (op.mode == MODE_CMP) ? acc_q : (op.mode == MODE_CPX) ? x_q : y_q;
                diff = cmp_reg - op.operand;
                status_q[FLAG_N_BIT] = diff[7];
                status_q[FLAG_Z_BIT] = (cmp_reg == op.operand);
                status_q[FLAG_C_BIT] = (cmp_reg >= op.operand);
            end
            MODE_INX:
            begin
                x_q = x_q + 8'd1;
                status_q = with_nz(status_q, x_q);
            end
            MODE_INY:
            begin
                y_q = y_q + 8'd1;
                status_q = with_nz(status_q, y_q);
            end
            MODE_DEX:
            begin
                x_q = x_q - 8'd1;
                status_q = with_nz(status_q, x_q);
            end
            MODE_LDA:
            begin
                acc_q = op.operand;
                status_q = with_nz(status_q, acc_q);
            end
            MODE_LDX:
            begin
                x_q = op.operand;
                status_q = with_nz(status_q, x_q);
            end
            MODE_LDY:
            begin
                y_q = op.operand;
                status_q = with_nz(status_q, y_q);
            end
            MODE_TAX:
            begin
                x_q = acc_q;
                status_q = with_nz(status_q, x_q);
            end
            MODE_TAY:
            begin
                y_q = acc_q;
                status_q = with_nz(status_q, y_q);
            end
            MODE_STA:
            begin
                r.store_data = acc_q;
                r.store_valid = 1'b1;
            end
            MODE_STX:
            begin
                r.store_data = x_q;
                r.store_valid = 1'b1;
            end
            MODE_STY:
            begin
                r.store_data = y_q;
                r.store_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.acc_out = acc_q;
        r.xreg_out = x_q;
        r.yreg_out = y_q;
        r.flags_out = status_q;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %02h, actual %02h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            acc_q = 8'h00;
            x_q = 8'h00;
            y_q = 8'h00;
            status_q = STATUS_RESET;
            expected_results.delete();
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (op_valid && op_ready)
                execute_op(op_beat);
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result beat arrived with no operation outstanding.");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("acc_out", exp_r.acc_out, res_beat.acc_out);
                    check_field("xreg_out", exp_r.xreg_out, res_beat.xreg_out);
                    check_field("yreg_out", exp_r.yreg_out, res_beat.yreg_out);
                    check_field("flags_out", exp_r.flags_out, res_beat.flags_out);
                    check_field("store_data", exp_r.store_data, res_beat.store_data);
                    check_field("store_valid", {7'd0, exp_r.store_valid},
                                {7'd0, res_beat.store_valid});
                    checked++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the execute unit testbench: clock, reset, operation stimulus, result sink and verdict.
module tb_top
    import cre_pkg::*;
;

    localparam int unsigned NUM_OPS = 1050;
    localparam int unsigned IDLE_LIMIT = 200;

    logic        clk;
    logic        rst_n;
    bit          src_gaps_on;
    bit          snk_stalls_on;
    int unsigned sent;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    cre_chan_if #(.payload_t(in_item_t))  op_if ();
    cre_chan_if #(.payload_t(out_item_t)) res_if ();

    cpu8_register_flag_execute DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_in   (op_if),
        .res_out (res_if)
    );

    cre_exec_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_if.valid),
        .op_ready   (op_if.ready),
        .op_beat    (op_if.payload),
        .res_valid  (res_if.valid),
        .res_ready  (res_if.ready),
        .res_beat   (res_if.payload),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] pick_operand();
        logic [7:0] corners [5];
        corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_op(input mode_t mode, input logic [7:0] operand);
        int unsigned gap;
        in_item_t    op;
        gap = src_gaps_on ? $urandom_range(0, 10) : 0;
        op.mode = mode;
        op.operand = operand;
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid <= 1'b1;
        op_if.payload <= op;
        do @(posedge clk); while (!op_if.ready);
        sent++;
    endtask

    initial
    begin : sink_side
        int unsigned stall;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_stalls_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

    initial
    begin : stimulus
        int unsigned kind;
        int unsigned r;
        logic [7:0]  v;
        rst_n <= 1'b0;
        op_if.valid <= 1'b0;
        op_if.payload <= '0;
        sent = 0;
        src_gaps_on = 1'b0;
        snk_stalls_on = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(MODE_LDA, 8'h00);
        send_op(MODE_LDA, 8'h80);
        send_op(MODE_ADC, 8'h80);
        send_op(MODE_ADC, 8'hFF);
        send_op(MODE_ADC, 8'h7F);
        send_op(MODE_CMP, 8'h00);
        send_op(MODE_CMP, 8'hFF);
        send_op(MODE_CMP, 8'h80);
        send_op(MODE_LDX, 8'hFF);
        send_op(MODE_INX, 8'h00);
        send_op(MODE_DEX, 8'h55);
        send_op(MODE_CPX, 8'hFF);
        send_op(MODE_CPX, 8'h00);
        send_op(MODE_LDY, 8'hFF);
        send_op(MODE_INY, 8'hAA);
        send_op(MODE_CPY, 8'h01);
        send_op(MODE_CPY, 8'h00);
        send_op(MODE_TAX, 8'h00);
        send_op(MODE_TAY, 8'hFF);
        send_op(MODE_STA, 8'h00);
        send_op(MODE_STX, 8'hFF);
        send_op(MODE_STY, 8'h00);
        send_op(MODE_LDA, 8'h7F);
        send_op(MODE_ADC, 8'h01);

        while (sent < NUM_OPS)
        begin
            if (sent % 64 < 3)
            begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                snk_stalls_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                r = $urandom_range(0, 2);
                v = pick_operand();
                send_op(mode_t'(MODE_LDA + r), v);
                send_op(mode_t'(MODE_CMP + r), v + 8'($urandom_range(0, 2)) - 8'd1);
            end
            else if (kind == 2)
            begin
                send_op(MODE_LDA, pick_operand());
                send_op(MODE_ADC, pick_operand());
                send_op(MODE_ADC, pick_operand());
            end
            else
            begin
                send_op(mode_t'($urandom_range(0, 14)), pick_operand());
            end
        end
        op_if.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d operation beats over all fifteen modes, including load/compare pairs",
                 sent);
        $display("and add chains; %0d result beats were compared field by field.", checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
